// ===== sv/miniblock_delta_width_histogram_assert.svh =====
// assertion macros used by the checker file
`ifndef MINIBLOCK_DELTA_WIDTH_HISTOGRAM_ASSERT_SVH
`define MINIBLOCK_DELTA_WIDTH_HISTOGRAM_ASSERT_SVH

// checked on every rising edge of clk_i outside reset
`define MDWH_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mdwh assertion failed");

// checked on every rising edge of clk_i, reset included
`define MDWH_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("mdwh assertion failed");

`endif

// ===== sv/mdwh_pkg.sv =====
package mdwh_pkg;

  localparam int ID_BITS_DEF    = 31;
  localparam int COUNT_BITS_DEF = 32;
  localparam int DELTA_BITS     = 32;
  localparam int MAX_WIDTH      = 32;
  localparam int BIN_BITS       = 5;
  localparam int POW2_BINS      = 6;
  localparam int MAX_BLOCK      = 64;
  localparam int BSIZE_BITS     = 7;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POW2_WIDTHS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_ENABLE = 2'd2;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic [BSIZE_BITS-1:0] block_size;
    logic                  pow2_widths;
    logic                  count_enable;
  } cfg_t;

  // one queue entry: an optional block to count, optionally followed by emission
  typedef struct packed {
    logic                  finish;
    logic                  count;
    logic [DELTA_BITS-1:0] max_delta;
  } q_entry_t;

  function automatic logic [BSIZE_BITS-1:0] eff_block_size(input logic [BSIZE_BITS-1:0] bs);
    logic [BSIZE_BITS-1:0] r;
    if (bs == '0) begin
      r = BSIZE_BITS'(1);
    end else if (bs > BSIZE_BITS'(MAX_BLOCK)) begin
      r = BSIZE_BITS'(MAX_BLOCK);
    end else begin
      r = bs;
    end
    return r;
  endfunction

  // histogram entry for the largest delta of a block (bin w sits at w-1)
  function automatic logic [BIN_BITS-1:0] width_bin(input logic [DELTA_BITS-1:0] v,
                                                    input logic pow2);
    logic [5:0] w;
    logic [5:0] r;
    w = '0;
    for (int i = 0; i < DELTA_BITS; i++) begin
      if (v[i]) w = 6'(i + 1);
    end
    if (pow2) begin
      if (w <= 6'd1) r = 6'd1;
      else if (w <= 6'd2) r = 6'd2;
      else if (w <= 6'd4) r = 6'd4;
      else if (w <= 6'd8) r = 6'd8;
      else if (w <= 6'd16) r = 6'd16;
      else r = 6'd32;
    end else begin
      r = (w == 6'd0) ? 6'd1 : w;
    end
    return BIN_BITS'(r - 6'd1);
  endfunction

endpackage

// ===== sv/miniblock_delta_width_histogram.sv =====
// Mini block delta width histogram. Edges arrive ordered by source; each
// source's destination deltas are cut into blocks of block_size deltas, and
// the bit width of each block's largest delta is counted in a histogram. A
// finish item flushes the open block, sends out 6 (power-of-two widths) or 32
// (exact widths) results, the last one flagged by last_o, and clears the
// histogram and source tracking. Rate: one item per clock, set by the front
// end's subtract and compare on the incoming edge and the back end's width
// encode and bin increment. A finish item holds the back end while its results
// go out, longer if the output stalls; the two-entry queue between front
// and back absorbs block closes and finish items meanwhile, after which
// in_stall_o rises. There is no clearing pass after reset. The user must
// write configuration through cfg_index_i (0 block_size, 1 pow2_widths,
// 2 count_enable) only while the block is idle; the block does not enforce it.
module miniblock_delta_width_histogram #(
  parameter int ID_BITS    = mdwh_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = mdwh_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [ID_BITS-1:0]                   source_id_i,
  input  logic [ID_BITS-1:0]                   dest_id_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [5:0]                           bin_width_o,
  output logic [31:0]                          block_count_o,
  output logic                                 last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mdwh_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [mdwh_pkg::BSIZE_BITS-1:0]      cfg_data_i
);
  import mdwh_pkg::*;

  cfg_t     cfg_q;
  logic     push, full, pop, q_valid;
  q_entry_t push_entry, pop_entry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{block_size: BSIZE_BITS'(32), pow2_widths: 1'b1, count_enable: 1'b1};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BLOCK_SIZE:   cfg_q.block_size   <= cfg_data_i;
        CFG_POW2_WIDTHS:  cfg_q.pow2_widths  <= cfg_data_i[0];
        CFG_COUNT_ENABLE: cfg_q.count_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mdwh_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (full),
    .kind_i      (kind_i),
    .source_id_i (source_id_i),
    .dest_id_i   (dest_id_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  mdwh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  mdwh_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (pop_entry),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bin_width_o   (bin_width_o),
    .block_count_o (block_count_o),
    .last_o        (last_o)
  );

endmodule

// ===== sv/mdwh_queue.sv =====
module mdwh_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mdwh_pkg::q_entry_t  push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output mdwh_pkg::q_entry_t  pop_entry_o
);
  import mdwh_pkg::*;

  q_entry_t   entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign valid_o     = (cnt_q != 2'd0);
  assign pop_entry_o = entries_q[rd_ptr_q];

  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== sv/mdwh_front.sv =====
module mdwh_front #(
  parameter int ID_BITS = mdwh_pkg::ID_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                kind_i,
  input  logic [ID_BITS-1:0]  source_id_i,
  input  logic [ID_BITS-1:0]  dest_id_i,
  input  mdwh_pkg::cfg_t      cfg_i,
  output logic                push_o,
  output mdwh_pkg::q_entry_t  entry_o
);
  import mdwh_pkg::*;

  logic                  have_q, have_d;
  logic [ID_BITS-1:0]    last_src_q, last_src_d;
  logic [ID_BITS-1:0]    last_dest_q, last_dest_d;
  logic [BSIZE_BITS-1:0] sec_q, sec_d;
  logic [BSIZE_BITS-1:0] fill_q, fill_d;
  logic [DELTA_BITS-1:0] max_q, max_d;

  logic                  accept;
  logic [BSIZE_BITS-1:0] ebs;
  logic                  close_ok;
  logic [DELTA_BITS-1:0] delta;
  logic [DELTA_BITS-1:0] max_n;
  logic [BSIZE_BITS-1:0] fill_n;

  assign accept   = in_valid_i && !in_stall_i;
  assign ebs      = eff_block_size(cfg_i.block_size);
  assign close_ok = have_q && (sec_q >= ebs) && (fill_q != '0);
  assign delta    = DELTA_BITS'(dest_id_i) - DELTA_BITS'(last_dest_q);
  assign max_n    = (delta > max_q) ? delta : max_q;
  assign fill_n   = fill_q + BSIZE_BITS'(1);

  always_comb begin
    have_d      = have_q;
    last_src_d  = last_src_q;
    last_dest_d = last_dest_q;
    sec_d       = sec_q;
    fill_d      = fill_q;
    max_d       = max_q;
    push_o      = 1'b0;
    entry_o     = '{finish: 1'b0, count: 1'b0, max_delta: max_q};
    if (accept) begin
      if (kind_i == KIND_FINISH) begin
        push_o        = 1'b1;
        entry_o.finish = 1'b1;
        entry_o.count  = cfg_i.count_enable && close_ok;
        have_d      = 1'b0;
        last_src_d  = '0;
        last_dest_d = '0;
        sec_d       = '0;
        fill_d      = '0;
        max_d       = '0;
      end else if (cfg_i.count_enable) begin
        if (!have_q || (source_id_i != last_src_q)) begin
          // new source: close the open block of the previous one
          push_o        = close_ok;
          entry_o.count = close_ok;
          have_d      = 1'b1;
          last_src_d  = source_id_i;
          last_dest_d = dest_id_i;
          sec_d       = BSIZE_BITS'(1);
          fill_d      = '0;
          max_d       = '0;
        end else begin
          if (sec_q < BSIZE_BITS'(MAX_BLOCK)) sec_d = sec_q + BSIZE_BITS'(1);
          last_dest_d = dest_id_i;
          if (fill_n >= ebs) begin
            push_o            = 1'b1;
            entry_o.count     = 1'b1;
            entry_o.max_delta = max_n;
            fill_d = '0;
            max_d  = '0;
          end else begin
            fill_d = fill_n;
            max_d  = max_n;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      last_src_q  <= '0;
      last_dest_q <= '0;
      sec_q       <= '0;
      fill_q      <= '0;
      max_q       <= '0;
    end else begin
      have_q      <= have_d;
      last_src_q  <= last_src_d;
      last_dest_q <= last_dest_d;
      sec_q       <= sec_d;
      fill_q      <= fill_d;
      max_q       <= max_d;
    end
  end

endmodule

// ===== sv/mdwh_back.sv =====
module mdwh_back #(
  parameter int COUNT_BITS = mdwh_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mdwh_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  mdwh_pkg::q_entry_t  q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          bin_width_o,
  output logic [31:0]         block_count_o,
  output logic                last_o
);
  import mdwh_pkg::*;

  localparam int OutW = (COUNT_BITS < 32) ? COUNT_BITS : 32;

  logic [COUNT_BITS-1:0] hist_q [MAX_WIDTH];
  logic                  emit_q;
  logic [BIN_BITS-1:0]   k_q;
  logic                  out_valid_q;
  logic [5:0]            width_q;
  logic [31:0]           count_q;
  logic                  last_q;

  logic                  inc;
  logic [BIN_BITS-1:0]   inc_idx;
  logic                  load;
  logic                  last_k;
  logic [BIN_BITS-1:0]   emit_idx;

  assign q_pop_o = q_valid_i && !emit_q;
  assign inc     = q_pop_o && q_entry_i.count;
  assign inc_idx = width_bin(q_entry_i.max_delta, cfg_i.pow2_widths);
  assign load    = emit_q && (!out_valid_q || !out_stall_i);
  assign last_k  = cfg_i.pow2_widths ? (k_q == BIN_BITS'(POW2_BINS - 1))
                                     : (k_q == BIN_BITS'(MAX_WIDTH - 1));
  // power-of-two mode walks bins 1,2,4,...: entry 2^k - 1
  assign emit_idx = cfg_i.pow2_widths ? BIN_BITS'((32'd1 << k_q) - 32'd1) : k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) hist_q[i] <= '0;
    end else begin
      if (q_pop_o && q_entry_i.finish) begin
        emit_q <= 1'b1;
        k_q    <= '0;
      end else if (load) begin
        k_q <= k_q + BIN_BITS'(1);
        if (last_k) emit_q <= 1'b0;
      end
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      // all bins clear with the final entry, shown or not
      for (int i = 0; i < MAX_WIDTH; i++) begin
        if (load && last_k) begin
          hist_q[i] <= '0;
        end else if (inc && (inc_idx == BIN_BITS'(i))) begin
          hist_q[i] <= hist_q[i] + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      width_q <= 6'(emit_idx) + 6'd1;
      count_q <= 32'(hist_q[emit_idx][OutW-1:0]);
      last_q  <= last_k;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_width_o   = width_q;
  assign block_count_o = count_q;
  assign last_o        = last_q;

endmodule

// ===== sv/mdwh_checker.sv =====
`include "miniblock_delta_width_histogram_assert.svh"

module mdwh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  bin_width_o,
  input logic [31:0] block_count_o,
  input logic        last_o
);

  // a stalled result stays offered
  `MDWH_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)

  // a stalled result keeps its payload
  `MDWH_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(bin_width_o) && $stable(block_count_o) && $stable(last_o))

  // the histogram always ends on the widest bin
  `MDWH_ASSERT(a_last_bin, out_valid_o && last_o |-> bin_width_o == 6'd32)

  // entries of one histogram follow each other without gaps
  `MDWH_ASSERT(a_emit_burst, out_valid_o && !out_stall_i && !last_o |=> out_valid_o)

endmodule

bind miniblock_delta_width_histogram mdwh_checker u_checker (.*);

// ===== tb/tb_miniblock_delta_width_histogram.sv =====
`timescale 1ns / 100ps

module tb_miniblock_delta_width_histogram;
  import mdwh_pkg::*;

  localparam int ID_W = 31;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 220;
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam int WIDTH_STEPS [POW2_BINS] = '{1, 2, 4, 8, 16, 32};

  typedef struct packed {
    logic [5:0]  bin_width;
    logic [31:0] block_count;
    logic        last;
  } bin_entry_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    kind_i = KIND_EDGE;
  logic [ID_W-1:0]         source_id_i = '0;
  logic [ID_W-1:0]         dest_id_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [5:0]              bin_width_o;
  logic [31:0]             block_count_o;
  logic                    last_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [BSIZE_BITS-1:0]   cfg_data_i = '0;

  miniblock_delta_width_histogram #(
    .ID_BITS(ID_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .source_id_i  (source_id_i),
    .dest_id_i    (dest_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bin_width_o  (bin_width_o),
    .block_count_o(block_count_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // register copies and tracking state of the histogram predictor
  logic [BSIZE_BITS-1:0] reg_block_size = 7'd32;
  logic                  reg_pow2 = 1'b1;
  logic                  reg_count_en = 1'b1;
  logic                  src_open;
  logic [ID_W-1:0]       cur_source;
  logic [ID_W-1:0]       prev_dest;
  int unsigned           source_edges;
  int unsigned           fill;
  logic [31:0]           block_peak;
  logic [31:0]           width_bins [MAX_WIDTH];

  bin_entry_t pending_bins[$];
  int unsigned bin_errors = 0;
  bit gaps_on = 1'b1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned mini_block_len();
    if (reg_block_size == '0) return 1;
    if (reg_block_size > MAX_BLOCK) return MAX_BLOCK;
    return reg_block_size;
  endfunction

  function automatic int unsigned width_bin_of(logic [31:0] v);
    int unsigned w;
    w = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) w = i + 1;
    end
    if (reg_pow2) begin
      for (int k = 0; k < POW2_BINS; k++) begin
        if (w <= WIDTH_STEPS[k]) return WIDTH_STEPS[k];
      end
      return MAX_WIDTH;
    end
    return (w == 0) ? 1 : w;
  endfunction

  function automatic void count_block();
    int unsigned w;
    w = width_bin_of(block_peak);
    width_bins[w-1] = width_bins[w-1] + 32'd1;
  endfunction

  // a trailing block counts only once the source has a full block of edges
  function automatic void close_block();
    if (src_open && source_edges >= mini_block_len() && fill > 0) count_block();
  endfunction

  function automatic void clear_histogram();
    src_open = 1'b0;
    cur_source = '0;
    prev_dest = '0;
    source_edges = 0;
    fill = 0;
    block_peak = '0;
    for (int i = 0; i < MAX_WIDTH; i++) width_bins[i] = '0;
  endfunction

  function automatic void push_bin(int unsigned w, bit is_last);
    bin_entry_t ent;
    ent.bin_width = 6'(w);
    ent.block_count = width_bins[w-1];
    ent.last = is_last;
    pending_bins.insert(pending_bins.size(), ent);
  endfunction

  function automatic void update_histogram(logic kind, logic [ID_W-1:0] src,
                                           logic [ID_W-1:0] dst);
    logic [31:0] delta;
    if (kind == KIND_EDGE) begin
      if (!reg_count_en) return;
      if (!src_open || src != cur_source) begin
        close_block();
        src_open = 1'b1;
        cur_source = src;
        prev_dest = dst;
        source_edges = 1;
        fill = 0;
        block_peak = '0;
      end else begin
        delta = 32'(dst) - 32'(prev_dest);
        if (source_edges < MAX_BLOCK) source_edges++;
        fill++;
        if (delta > block_peak) block_peak = delta;
        if (fill >= mini_block_len()) begin
          count_block();
          fill = 0;
          block_peak = '0;
        end
        prev_dest = dst;
      end
      return;
    end
    if (reg_count_en) close_block();
    if (reg_pow2) begin
      for (int k = 0; k < POW2_BINS; k++) push_bin(WIDTH_STEPS[k], k == POW2_BINS - 1);
    end else begin
      for (int w = 1; w <= MAX_WIDTH; w++) push_bin(w, w == MAX_WIDTH);
    end
    clear_histogram();
  endfunction

  // mostly short idles, now and then a long one
  function automatic int unsigned random_idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_gap();
    if (!gaps_on) return 0;
    if ($urandom_range(0, 99) < 70) return 0;
    return random_idle_len();
  endfunction

  // entered and left just after a falling edge; valid stays high on exit
  task automatic send_item(input logic kind, input logic [ID_W-1:0] src,
                           input logic [ID_W-1:0] dst);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    source_id_i <= src;
    dest_id_i <= dst;
    do @(posedge clk_i); while (in_stall_o);
    update_histogram(kind, src, dst);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [BSIZE_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BLOCK_SIZE:   reg_block_size = data;
      CFG_POW2_WIDTHS:  reg_pow2 = data[0];
      CFG_COUNT_ENABLE: reg_count_en = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // edge items leave no result behind, so give the pipeline time to empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_width_extremes();
    write_reg(CFG_BLOCK_SIZE, 7'd0);
    send_item(KIND_EDGE, '0, '0);
    send_item(KIND_EDGE, '0, ID_MAX);
    // destination going down wraps to a huge delta
    send_item(KIND_EDGE, '0, '0);
    send_item(KIND_EDGE, '0, '0);
    send_item(KIND_EDGE, ID_MAX, 31'd1);
    send_item(KIND_EDGE, ID_MAX, 31'd3);
    send_item(KIND_EDGE, ID_MAX, 31'd203);
    send_item(KIND_FINISH, ID_MAX, ID_MAX);
    settle();
  endtask

  task automatic test_exact_widths();
    write_reg(CFG_BLOCK_SIZE, 7'd1);
    write_reg(CFG_POW2_WIDTHS, 7'd0);
    send_item(KIND_EDGE, 31'd5, 31'd10);
    send_item(KIND_EDGE, 31'd5, 31'd17);
    send_item(KIND_EDGE, 31'd5, 31'd17 + (31'd1 << 20));
    send_item(KIND_FINISH, '0, '0);
    send_item(KIND_EDGE, 31'd6, 31'd0);
    send_item(KIND_EDGE, 31'd6, 31'd5);
    settle();
    // width 3 bin is hidden in power-of-two mode but must still be cleared
    write_reg(CFG_POW2_WIDTHS, 7'd1);
    send_item(KIND_FINISH, '0, '0);
    settle();
    write_reg(CFG_POW2_WIDTHS, 7'd0);
    send_item(KIND_FINISH, '0, '0);
    settle();
  endtask

  task automatic test_partial_blocks();
    write_reg(CFG_BLOCK_SIZE, 7'd4);
    write_reg(CFG_POW2_WIDTHS, 7'd1);
    send_item(KIND_EDGE, 31'd7, 31'd0);
    send_item(KIND_EDGE, 31'd7, 31'd1);
    send_item(KIND_EDGE, 31'd7, 31'd2);
    send_item(KIND_EDGE, 31'd7, 31'd3);
    send_item(KIND_EDGE, 31'd7, 31'd4);
    send_item(KIND_EDGE, 31'd7, 31'd100);
    // short source: its trailing block is dropped
    send_item(KIND_EDGE, 31'd8, 31'd0);
    send_item(KIND_EDGE, 31'd8, 31'd50);
    send_item(KIND_FINISH, '0, '0);
    settle();
  endtask

  task automatic test_count_disabled();
    write_reg(CFG_BLOCK_SIZE, 7'd2);
    send_item(KIND_EDGE, 31'd11, 31'd0);
    send_item(KIND_EDGE, 31'd11, 31'd1);
    send_item(KIND_EDGE, 31'd11, 31'd2);
    send_item(KIND_EDGE, 31'd11, 31'd9);
    settle();
    // open block is not flushed while counting is off
    write_reg(CFG_COUNT_ENABLE, 7'd0);
    send_item(KIND_EDGE, 31'd9, 31'd0);
    send_item(KIND_EDGE, 31'd9, 31'd1);
    send_item(KIND_FINISH, '0, '0);
    settle();
    write_reg(CFG_COUNT_ENABLE, 7'd1);
  endtask

  task automatic test_random_streams();
    int unsigned sent, used, budget, n_edges, blen, pick, k;
    logic [BSIZE_BITS-1:0] bsize;
    logic [ID_W-1:0] src, dst, last_src, older_src;
    logic [31:0] step;
    sent = 0;
    last_src = '0;
    older_src = '0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 9);
      case (pick)
        0: bsize = 7'd0;
        1: bsize = 7'd1;
        2: bsize = 7'd64;
        3: bsize = 7'($urandom_range(65, 127));
        default: bsize = 7'($urandom_range(2, 8));
      endcase
      write_reg(CFG_BLOCK_SIZE, bsize);
      write_reg(CFG_POW2_WIDTHS, 7'($urandom_range(0, 1)));
      write_reg(CFG_COUNT_ENABLE, 7'($urandom_range(0, 5) != 0));
      blen = mini_block_len();
      budget = $urandom_range(30, 70);
      used = 0;
      while (used < budget) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) src = older_src;
        else if (pick == 1) src = last_src + 31'd1;
        else src = ID_W'($urandom);
        older_src = last_src;
        last_src = src;
        pick = $urandom_range(0, 9);
        if (pick < 6) n_edges = $urandom_range(blen + 1, 2 * blen + 2);
        else if (pick < 9) n_edges = $urandom_range(1, blen);
        else n_edges = $urandom_range(1, 3);
        dst = $urandom_range(0, 1) ? ID_W'($urandom) : ID_W'($urandom_range(0, 1000));
        repeat (n_edges) begin
          send_item(KIND_EDGE, src, dst);
          used++;
          sent++;
          if ($urandom_range(0, 19) == 0) begin
            dst = ID_W'($urandom);
          end else begin
            k = $urandom_range(0, 31);
            step = (k == 0) ? 32'd0 : ($urandom >> (32 - k));
            dst = dst + step[ID_W-1:0];
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          send_item(KIND_FINISH, ID_W'($urandom), ID_W'($urandom));
          used++;
          sent++;
        end
      end
      send_item(KIND_FINISH, ID_W'($urandom), ID_W'($urandom));
      sent++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin : out_stall_gen
    int unsigned hold, stretch;
    bit calm;
    hold = 0;
    stretch = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        stretch = $urandom_range(30, 200);
        calm = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        hold = random_idle_len() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_bins
    bin_entry_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bins.size() == 0) begin
        bin_errors++;
        if (bin_errors <= 10)
          $display("unexpected histogram transfer: width %0d count %0d last %0b",
                   bin_width_o, block_count_o, last_o);
      end else begin
        want = pending_bins.pop_front();
        if (bin_width_o !== want.bin_width || block_count_o !== want.block_count ||
            last_o !== want.last) begin
          bin_errors++;
          if (bin_errors <= 10)
            $display("histogram mismatch: exp width %0d count %0d last %0b, got width %0d count %0d last %0b",
                     want.bin_width, want.block_count, want.last,
                     bin_width_o, block_count_o, last_o);
        end
      end
    end
  end

  initial begin
    clear_histogram();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_width_extremes();
    test_exact_widths();
    test_partial_blocks();
    test_count_disabled();
    test_random_streams();
    settle();
    if (bin_errors == 0 && pending_bins.size() == 0) begin
      $display("tb_miniblock_delta_width_histogram passed");
    end else begin
      $display("tb_miniblock_delta_width_histogram failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_miniblock_delta_width_histogram failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mdwh_pkg.sv
sv/mdwh_queue.sv
sv/mdwh_front.sv
sv/mdwh_back.sv
sv/miniblock_delta_width_histogram.sv
sv/mdwh_checker.sv
tb/tb_miniblock_delta_width_histogram.sv
